/* sv/framed_state_feedback_controller_defines.svh */
// Assertion macros used by the port-level checker of the framed controller.
`ifndef FRAMED_STATE_FEEDBACK_CONTROLLER_DEFINES_SVH
`define FRAMED_STATE_FEEDBACK_CONTROLLER_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define FSFC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FSFC_ASSERT_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/fsfc_pkg.sv */
// Shared types, constants and register codes of the framed state-feedback controller.
`default_nettype none

package fsfc_pkg;

    localparam int FRAME_LEN   = 16;
    localparam int STORE_DEPTH = 10;
    localparam int POS_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int NUM_MEAS    = 4;
    localparam int NUM_GAINS   = 8;
    localparam int GAIN_W      = 24;
    localparam int PROD_W      = GAIN_W + WORD_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int Q_FRAC      = 16;

    localparam int ADDR_W      = 5;
    localparam int REG_IDX_W   = 3;
    localparam int DATA_W      = 32;

    localparam logic [WORD_W-1:0] FRAME_ID   = WORD_W'(109);
    localparam logic [BYTE_W-1:0] REPLY_FLAG = BYTE_W'(99);

    localparam logic signed [ACC_W-1:0] OFFSET_A_Q = ACC_W'(127) << Q_FRAC;
    localparam logic signed [ACC_W-1:0] OFFSET_B_Q = ACC_W'(125) << Q_FRAC;

    // Register indexes
    localparam int unsigned G_A_POS1    = 0;
    localparam int unsigned G_A_POS2    = 1;
    localparam int unsigned G_A_STRAIN1 = 2;
    localparam int unsigned G_A_STRAIN2 = 3;
    localparam int unsigned G_B_POS1    = 4;
    localparam int unsigned G_B_POS2    = 5;
    localparam int unsigned G_B_STRAIN1 = 6;
    localparam int unsigned G_B_STRAIN2 = 7;

    typedef logic [NUM_GAINS-1:0][GAIN_W-1:0] t_gain_arr;

    typedef struct packed {
        logic                             valid;
        logic                             id_ok;
        logic [NUM_MEAS-1:0][WORD_W-1:0]  meas;
    } t_frame;

    typedef struct packed {
        logic              valid;
        logic              id_ok;
        logic [BYTE_W-1:0] drive_a;
        logic [BYTE_W-1:0] drive_b;
    } t_drive_res;

    function automatic logic [GAIN_W-1:0] gain_reset(input int unsigned idx);
        logic [GAIN_W-1:0] v;
        case (idx)
            G_A_POS1:    v = GAIN_W'(-101680);
            G_A_STRAIN1: v = GAIN_W'(508);
            G_B_POS2:    v = GAIN_W'(-152520);
            G_B_STRAIN2: v = GAIN_W'(254);
            default:     v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* sv/fsfc_regs.sv */
// Gain register file behind the APB-style configuration port.
`default_nettype none

module fsfc_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fsfc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [fsfc_pkg::DATA_W-1:0]   pwdata,
    output logic      [fsfc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output fsfc_pkg::t_gain_arr                o_gains
);
    import fsfc_pkg::*;

    t_gain_arr             r_gain;
    logic [REG_IDX_W-1:0]  idx;
    logic                  wr;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = {{(DATA_W-GAIN_W){r_gain[idx][GAIN_W-1]}}, r_gain[idx]};
    assign o_gains = r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_GAINS; i++) begin
                r_gain[i] <= gain_reset(i);
            end
        end else if (wr) begin
            r_gain[idx] <= pwdata[GAIN_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* sv/fsfc_framer.sv */
// Byte collector: frame position, byte store and measurement snapshot on frame end.
`default_nettype none

module fsfc_framer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [fsfc_pkg::BYTE_W-1:0]  i_rx_byte,
    output fsfc_pkg::t_frame                  o_frame,
    output logic                              o_frame_end
);
    import fsfc_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    logic [POS_W-1:0]                     r_pos, n_pos;
    logic [STORE_DEPTH-1:0][BYTE_W-1:0]   r_store, n_store;
    logic                                 r_valid, n_valid;
    logic                                 r_id_ok, n_id_ok;
    logic [NUM_MEAS-1:0][WORD_W-1:0]      r_meas, n_meas;

    assign o_frame_end = (r_pos == LAST_POS);

    always_comb begin
        n_store = r_store;
        n_pos   = r_pos;
        // The current byte is visible to the snapshot taken at this edge
        if (i_accept && (r_pos < POS_W'(STORE_DEPTH))) begin
            n_store[r_pos] = i_rx_byte;
        end
        if (i_accept) begin
            n_pos = o_frame_end ? '0 : r_pos + 1'b1;
        end
        n_valid = i_accept && o_frame_end;
        n_id_ok = ({n_store[1], n_store[0]} == FRAME_ID);
        for (int k = 0; k < NUM_MEAS; k++) begin
            n_meas[k] = {n_store[2*k+3], n_store[2*k+2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
        r_id_ok <= n_id_ok;
        r_meas  <= n_meas;
    end

    assign o_frame = '{valid: r_valid, id_ok: r_id_ok, meas: r_meas};

endmodule

`default_nettype wire

/* sv/fsfc_drive.sv */
// Drive arithmetic: product stage, pair-sum stage, final sum with offset and clamp.
`default_nettype none

module fsfc_drive (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fsfc_pkg::t_frame    i_frame,
    input  wire fsfc_pkg::t_gain_arr i_gains,
    output fsfc_pkg::t_drive_res     o_res,
    output logic                     o_busy
);
    import fsfc_pkg::*;

    localparam logic signed [ACC_W-1:0] LIMIT_Q = ACC_W'(256) << Q_FRAC;

    logic signed [PROD_W-1:0] r_prod [NUM_GAINS];
    logic signed [PROD_W-1:0] n_prod [NUM_GAINS];
    logic signed [ACC_W-1:0]  r_pair [NUM_MEAS];
    logic signed [ACC_W-1:0]  n_pair [NUM_MEAS];
    logic signed [ACC_W-1:0]  acc_a, acc_b;
    logic                     r_v1, r_v2, r_v3;
    logic                     r_ok1, r_ok2, r_ok3;
    logic [BYTE_W-1:0]        r_da, r_db;

    function automatic logic [BYTE_W-1:0] clamp_drive(input logic signed [ACC_W-1:0] acc);
        logic [BYTE_W-1:0] d;
        if (acc < 0) begin
            d = '0;
        end else if (acc >= LIMIT_Q) begin
            d = '1;
        end else begin
            d = acc[Q_FRAC +: BYTE_W];
        end
        return d;
    endfunction

    always_comb begin
        // Gains 0..3 drive A, 4..7 drive B, each over words 1..4 in order
        for (int j = 0; j < NUM_GAINS; j++) begin
            n_prod[j] = $signed(i_gains[j]) * $signed(i_frame.meas[j % NUM_MEAS]);
        end
        for (int p = 0; p < NUM_MEAS; p++) begin
            n_pair[p] = ACC_W'(r_prod[2*p]) + ACC_W'(r_prod[2*p+1]);
        end
        acc_a = r_pair[0] + r_pair[1] + OFFSET_A_Q;
        acc_b = r_pair[2] + r_pair[3] + OFFSET_B_Q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_frame.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_pair <= n_pair;
        r_ok1  <= i_frame.id_ok;
        r_ok2  <= r_ok1;
        r_ok3  <= r_ok2;
        r_da   <= clamp_drive(acc_a);
        r_db   <= clamp_drive(acc_b);
    end

    assign o_res  = '{valid: r_v3, id_ok: r_ok3, drive_a: r_da, drive_b: r_db};
    assign o_busy = r_v1 || r_v2 || r_v3;

endmodule

`default_nettype wire

/* sv/fsfc_reply.sv */
// Reply sequencer: holds one frame's reply and feeds it through the output register.
`default_nettype none

module fsfc_reply (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire fsfc_pkg::t_drive_res         i_res,
    input  wire logic                         i_stall,
    output logic                              o_valid,
    output logic [fsfc_pkg::BYTE_W-1:0]       o_tx_byte,
    output logic                              o_last_of_reply,
    output logic                              o_frame_error,
    output logic                              o_busy
);
    import fsfc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LAST  = 4'b0010,
        ST_DRV_A = 4'b0100,
        ST_FLAG  = 4'b1000
    } t_reply_state;

    t_reply_state      r_state, n_state;
    logic              r_err;
    logic [BYTE_W-1:0] r_da, r_db;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, r_out_err;
    logic              adv;

    assign adv = (r_state != ST_IDLE) && (!r_out_valid || !i_stall);

    always_comb begin
        n_out_byte = '0;
        n_state    = ST_IDLE;
        case (r_state)
            ST_FLAG: begin
                n_out_byte = REPLY_FLAG;
                n_state    = ST_DRV_A;
            end
            ST_DRV_A: begin
                n_out_byte = r_da;
                n_state    = ST_LAST;
            end
            ST_LAST: begin
                n_out_byte = r_err ? '0 : r_db;
                n_state    = ST_IDLE;
            end
            default: begin
                n_out_byte = '0;
                n_state    = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // A new reply must land only once the previous one has left the state machine; not enforced here.
            if (i_res.valid) begin
                r_state <= i_res.id_ok ? ST_FLAG : ST_LAST;
            end else if (adv) begin
                r_state <= n_state;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_err <= !i_res.id_ok;
            r_da  <= i_res.drive_a;
            r_db  <= i_res.drive_b;
        end
        if (adv) begin
            r_out_byte <= n_out_byte;
            r_out_last <= (r_state == ST_LAST);
            r_out_err  <= (r_state == ST_LAST) && r_err;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_tx_byte       = r_out_byte;
    assign o_last_of_reply = r_out_last;
    assign o_frame_error   = r_out_err;
    assign o_busy          = (r_state != ST_IDLE);

endmodule

`default_nettype wire

/* sv/framed_state_feedback_controller.sv */
// Top level of the framed state-feedback controller.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  rx      | in        | i_valid / o_stall    | i_rx_byte
//  tx      | out       | o_valid / i_stall    | o_tx_byte, o_last_of_reply, o_frame_error
//  cfg     | in        | psel/penable/pready  | paddr, pwdata, prdata (eight Q8.16 gains)
//
// One rx word is taken per cycle unless o_stall holds it. A frame's reply is held in a
// three-stage drive pipeline (products, pair sums, final sum and clamp) and a reply
// buffer; the framer snapshot, drive stages, reply state and output register lead to tx.
// The last word of a frame is held off (o_stall high) while the drive pipeline or the
// reply buffer still carries the previous frame; all other rx words pass freely.
// Reset is synchronous, active low: it clears the frame position, all valids and
// loads the gains with their defaults. The byte store is not reset.
`default_nettype none

module framed_state_feedback_controller (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // rx channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [fsfc_pkg::BYTE_W-1:0]   i_rx_byte,
    // tx channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [fsfc_pkg::BYTE_W-1:0]   o_tx_byte,
    output logic                               o_last_of_reply,
    output logic                               o_frame_error,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fsfc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [fsfc_pkg::DATA_W-1:0]   pwdata,
    output logic      [fsfc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import fsfc_pkg::*;

    t_gain_arr  gains;
    t_frame     frame;
    t_drive_res drive_res;
    logic       frame_end;
    logic       drive_busy;
    logic       reply_busy;
    logic       rx_accept;

    // Hold the frame-ending word until the previous reply has left the drive pipeline and reply state
    assign o_stall   = frame_end && (drive_busy || reply_busy);
    assign rx_accept = i_valid && !o_stall;

    fsfc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gains (gains)
    );

    // Collect bytes; snapshot identifier check and words 1..4 on the last byte
    fsfc_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (rx_accept),
        .i_rx_byte   (i_rx_byte),
        .o_frame     (frame),
        .o_frame_end (frame_end)
    );

    // Both drive values: multiply, add in pairs, add offset and clamp to a byte
    fsfc_drive u_drive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame),
        .i_gains (gains),
        .o_res   (drive_res),
        .o_busy  (drive_busy)
    );

    // Emit flag, drive 1, drive 2 (or one error word) through the output register
    fsfc_reply u_reply (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_res           (drive_res),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_tx_byte       (o_tx_byte),
        .o_last_of_reply (o_last_of_reply),
        .o_frame_error   (o_frame_error),
        .o_busy          (reply_busy)
    );

endmodule

`default_nettype wire

/* sv/fsfc_checker.sv */
// Port-level checker of the framed controller and its bind.
`default_nettype none
`include "framed_state_feedback_controller_defines.svh"

module fsfc_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          o_stall,
    input  wire logic [fsfc_pkg::BYTE_W-1:0]   i_rx_byte,
    input  wire logic                          o_valid,
    input  wire logic                          i_stall,
    input  wire logic [fsfc_pkg::BYTE_W-1:0]   o_tx_byte,
    input  wire logic                          o_last_of_reply,
    input  wire logic                          o_frame_error,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fsfc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [fsfc_pkg::DATA_W-1:0]   pwdata,
    input  wire logic [fsfc_pkg::DATA_W-1:0]   prdata,
    input  wire logic                          pready
);

    `FSFC_ASSERT_RST(a_tx_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_tx_byte) && $stable(o_last_of_reply) && $stable(o_frame_error), "tx word changed while stalled")
    `FSFC_ASSERT_RST(a_err_word, i_clk, i_rst_n, o_valid && o_frame_error |-> o_tx_byte == 8'd0 && o_last_of_reply, "error word must be zero and last")
    `FSFC_ASSERT_RST(a_err_last_only, i_clk, i_rst_n, o_valid && !o_last_of_reply |-> !o_frame_error, "error flag on a word that is not last")
    `FSFC_ASSERT_ALW(a_rst_quiet, i_clk, !i_rst_n |=> !o_valid, "tx valid right after reset")

endmodule

bind framed_state_feedback_controller fsfc_checker u_fsfc_checker (.*);

`default_nettype wire

/* verif/fsfc_reply_checker.sv */
`timescale 1ns / 100ps
// Reply predictor and scoreboard for the framed state-feedback controller.
module fsfc_reply_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          rx_valid,
    input  logic                          rx_stall,
    input  logic [fsfc_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          tx_valid,
    input  logic                          tx_stall,
    input  logic [fsfc_pkg::BYTE_W-1:0]   tx_byte,
    input  logic                          tx_last,
    input  logic                          tx_error,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [fsfc_pkg::ADDR_W-1:0]   paddr,
    input  logic [fsfc_pkg::DATA_W-1:0]   pwdata,
    output int                            mismatch_count,
    output int                            replies_outstanding
);
    import fsfc_pkg::*;

    localparam int ADDR_LSB = 2;
    localparam longint DRIVE_A_OFFSET = 127;
    localparam longint DRIVE_B_OFFSET = 125;
    localparam logic [BYTE_W-1:0] DRIVE_MAX = 8'd255;

    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic              last;
        logic              err;
    } t_reply_word;

    logic signed [GAIN_W-1:0] gain [NUM_GAINS];
    logic [BYTE_W-1:0]        frame_bytes [STORE_DEPTH];
    int unsigned              byte_pos;
    t_reply_word              reply_q [$];

    function automatic logic [GAIN_W-1:0] default_gain(input int unsigned r);
        case (r)
            G_A_POS1:    return GAIN_W'(-101680);
            G_A_STRAIN1: return GAIN_W'(508);
            G_B_POS2:    return GAIN_W'(-152520);
            G_B_STRAIN2: return GAIN_W'(254);
            default:     return '0;
        endcase
    endfunction

    // Little-endian word w of the current frame, signed.
    function automatic logic signed [WORD_W-1:0] meas_word(input int unsigned w);
        return {frame_bytes[(2 * w + 1) % STORE_DEPTH], frame_bytes[(2 * w) % STORE_DEPTH]};
    endfunction

    // Exact sum, in 16 fraction bits, of four Q8.16 gain-weighted words plus offset, clamped to a byte.
    function automatic logic [BYTE_W-1:0] drive_byte(input int unsigned first_gain,
                                                     input longint offset);
        longint acc;
        acc = offset <<< Q_FRAC;
        for (int k = 0; k < NUM_MEAS; k++)
            acc += longint'(gain[first_gain + k]) * longint'(meas_word(k + 1));
        if (acc < 0)
            return '0;
        if (acc >= (longint'(256) <<< Q_FRAC))
            return DRIVE_MAX;
        return BYTE_W'(acc >>> Q_FRAC);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_reply_word got;
        t_reply_word want;
        int unsigned idx;
        if (!i_rst_n) begin
            for (int r = G_A_POS1; r <= G_B_STRAIN2; r++)
                gain[r] = default_gain(r);
            byte_pos = 0;
            reply_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                idx = paddr >> ADDR_LSB;
                if (idx < NUM_GAINS)
                    gain[idx] = pwdata[GAIN_W-1:0];
            end
            // Check the outgoing word first: it can never belong to a frame ending now.
            if (tx_valid && !tx_stall) begin
                got = '{tx_byte, tx_last, tx_error};
                if (reply_q.size() == 0) begin
                    $error("unexpected tx word: tx_byte %0d last %0b error %0b",
                           got.tx_byte, got.last, got.err);
                    mismatch_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (got.tx_byte !== want.tx_byte) begin
                        $error("tx_byte: expected %0d, got %0d", want.tx_byte, got.tx_byte);
                        mismatch_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_of_reply: expected %0b, got %0b", want.last, got.last);
                        mismatch_count++;
                    end
                    if (got.err !== want.err) begin
                        $error("frame_error: expected %0b, got %0b", want.err, got.err);
                        mismatch_count++;
                    end
                end
            end
            if (rx_valid && !rx_stall) begin
                if (byte_pos < STORE_DEPTH)
                    frame_bytes[byte_pos] = rx_byte;
                if (byte_pos + 1 < FRAME_LEN) begin
                    byte_pos++;
                end else begin
                    byte_pos = 0;
                    if (WORD_W'(meas_word(0)) != FRAME_ID) begin
                        reply_q.push_back('{'0, 1'b1, 1'b1});
                    end else begin
                        reply_q.push_back('{REPLY_FLAG, 1'b0, 1'b0});
                        reply_q.push_back('{drive_byte(G_A_POS1, DRIVE_A_OFFSET), 1'b0, 1'b0});
                        reply_q.push_back('{drive_byte(G_B_POS1, DRIVE_B_OFFSET), 1'b1, 1'b0});
                    end
                end
            end
        end
        replies_outstanding = reply_q.size();
    end

endmodule

/* verif/framed_state_feedback_controller_test.sv */
`timescale 1ns / 100ps
// Stimulus, handshake pacing and verdict for the framed state-feedback controller.
module framed_state_feedback_controller_test;
    import fsfc_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 11;
    // Leave margin past the time the reply takes to reach tx after the last rx word.
    localparam int DRAIN_CYCLES   = 12;
    localparam int LONG_HOLD      = 300;
    localparam int IDLE_LIMIT     = 2000;
    localparam int REG_STRIDE     = 4;
    localparam int WARMUP_FRAMES  = 1;
    localparam int PHASE_FRAMES   = 1;
    localparam int HOLD_FRAMES    = 3;

    // Gain sets visited after the reset defaults.
    typedef enum int {
        GS_MAX,
        GS_MIN,
        GS_SMALL,
        GS_FULL,
        GS_SPARSE,
        GS_MIXED,
        GS_COUNT
    } t_gain_set;

    // Phase that runs under a long tx hold-off, and phase with a sender pause.
    localparam t_gain_set HOLD_SET  = GS_SMALL;
    localparam t_gain_set PAUSE_SET = GS_FULL;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [BYTE_W-1:0]   i_rx_byte;
    logic                o_valid;
    logic                i_stall;
    logic [BYTE_W-1:0]   o_tx_byte;
    logic                o_last_of_reply;
    logic                o_frame_error;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int                  mismatch_count;
    int                  replies_outstanding;
    int                  idle_cycles = 0;
    bit                  rx_gaps_on = 1'b0;
    bit                  long_hold_req = 1'b0;

    always #(CLK_HALF) i_clk = ~i_clk;

    framed_state_feedback_controller u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_tx_byte       (o_tx_byte),
        .o_last_of_reply (o_last_of_reply),
        .o_frame_error   (o_frame_error),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    fsfc_reply_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .rx_valid            (i_valid),
        .rx_stall            (o_stall),
        .rx_byte             (i_rx_byte),
        .tx_valid            (o_valid),
        .tx_stall            (i_stall),
        .tx_byte             (o_tx_byte),
        .tx_last             (o_last_of_reply),
        .tx_error            (o_frame_error),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .pready              (pready),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .mismatch_count      (mismatch_count),
        .replies_outstanding (replies_outstanding)
    );

    // Watchdog: end the run when no word moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // tx receiver: alternate quiet stretches with short and long stalls.
    // Serve one long hold-off when the stimulus asks for it, so the block backs up.
    initial begin : tx_pacer
        int hold_left;
        int free_left;
        int pick;
        hold_left = 0;
        free_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (free_left > 0) begin
                i_stall <= 1'b0;
                free_left--;
            end else begin
                i_stall <= 1'b0;
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    free_left = $urandom_range(10, 60);
                else if (pick < 92)
                    hold_left = $urandom_range(1, 3);
                else
                    hold_left = $urandom_range(15, 40);
            end
        end
    end

    // Gap before the next rx word: mostly none, some short, a few long.
    function automatic int rx_gap();
        int pick;
        if (!rx_gaps_on)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        if (pick < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one rx word and hold it until the block takes it.
    // Leave valid high on return: the next call either replaces the word or drops valid.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = rx_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic rx_quiet();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Send words 0..4 little-endian, then fill the rest of the frame with noise.
    task automatic send_frame(input logic [4:0][WORD_W-1:0] words);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < FRAME_LEN; i++) begin
            if (i < 2 * 5)
                b = words[i / 2][(i % 2) * BYTE_W +: BYTE_W];
            else
                b = BYTE_W'($urandom);
            send_byte(b);
        end
    endtask

    function automatic logic [WORD_W-1:0] pick_meas();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4, 5:    return WORD_W'(int'($urandom_range(0, 800)) - 400);
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // Mostly well-formed frames; some carry a wrong identifier.
    task automatic send_random_frame();
        logic [4:0][WORD_W-1:0] w;
        int pick;
        pick = $urandom_range(0, 9);
        w[0] = FRAME_ID;
        if (pick == 0) begin
            w[0] = WORD_W'($urandom);
            if (w[0] == FRAME_ID)
                w[0] = w[0] ^ 16'h8000;
        end else if (pick == 1) begin
            w[0] = FRAME_ID ^ (16'h0001 << $urandom_range(0, WORD_W - 1));
        end
        for (int k = 1; k <= NUM_MEAS; k++)
            w[k] = pick_meas();
        send_frame(w);
    endtask

    task automatic write_gain(input int unsigned r, input logic [GAIN_W-1:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(r * REG_STRIDE);
        pwdata  <= {{(DATA_W - GAIN_W){v[GAIN_W-1]}}, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_replies();
        while (replies_outstanding != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [GAIN_W-1:0] small_gain();
        return GAIN_W'(int'($urandom_range(0, 1200)) - 600);
    endfunction

    // Reprogram every gain; only call with the block drained.
    task automatic load_gain_set(input t_gain_set gs);
        logic [GAIN_W-1:0] v;
        for (int r = G_A_POS1; r <= G_B_STRAIN2; r++) begin
            case (gs)
                GS_MAX:    v = 24'h7FFFFF;
                GS_MIN:    v = 24'h800000;
                GS_SMALL:  v = small_gain();
                GS_FULL:   v = GAIN_W'($urandom);
                GS_SPARSE: v = (r == G_A_POS1 || r == G_B_POS2) ? small_gain() : '0;
                default: begin
                    case ($urandom_range(0, 3))
                        0:       v = '0;
                        1:       v = 24'h7FFFFF;
                        2:       v = 24'h800000;
                        default: v = small_gain();
                    endcase
                end
            endcase
            write_gain(r, v);
        end
    endtask

    initial begin : stimulus
        int n_frames;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_rx_byte = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, default gains, back to back: extreme measurement words drive
        // both outputs into their clamps, then a frame whose identifier differs
        // only in the high byte must give a single error word and resync.
        send_frame({16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, FRAME_ID});
        send_frame({16'h1234, 16'h0001, 16'h7FFF, 16'h8000, FRAME_ID | 16'h0100});

        rx_gaps_on = 1'b1;
        repeat (WARMUP_FRAMES) send_random_frame();

        for (int p = 0; p < GS_COUNT; p++) begin
            // Drain the block fully before touching the gains.
            rx_quiet();
            wait_replies();
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            load_gain_set(t_gain_set'(p));

            n_frames = PHASE_FRAMES;
            if (p == HOLD_SET) begin
                // Keep offering words with no gaps while tx holds off.
                rx_gaps_on    = 1'b0;
                long_hold_req = 1'b1;
                n_frames      = HOLD_FRAMES;
            end
            for (int f = 0; f < n_frames; f++) begin
                send_random_frame();
                if (p == PAUSE_SET && f == 0) begin
                    // Hold the sender until every pending reply word is out.
                    rx_quiet();
                    wait_replies();
                end
            end
            rx_gaps_on = 1'b1;
        end

        rx_quiet();
        wait_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (replies_outstanding != 0)
            $error("%0d reply words never arrived", replies_outstanding);
        if (mismatch_count == 0 && replies_outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* framed_state_feedback_controller.f */
+incdir+sv
sv/fsfc_pkg.sv
sv/fsfc_regs.sv
sv/fsfc_framer.sv
sv/fsfc_drive.sv
sv/fsfc_reply.sv
sv/framed_state_feedback_controller.sv
sv/fsfc_checker.sv
verif/fsfc_reply_checker.sv
verif/framed_state_feedback_controller_test.sv
